FILE: hdl/seau_pkg.sv
// Shared constants, types and register indexes for the Sampson error accumulator.
package seau_pkg;

  localparam int CoordFracBits = 4;
  localparam int LineShift     = 18;
  localparam int ErrShift      = 16 - 2 * CoordFracBits;
  localparam int ErrW          = 48;
  localparam int SumW          = 63;
  localparam int CoordW        = 16;
  localparam int CoefW         = 32;
  localparam int ProdW         = CoefW + CoordW;
  localparam int AccW          = 64;
  localparam int DivW          = 128;

  localparam logic [ErrW-1:0] ErrMax = {ErrW{1'b1}};
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [2:0] {
    REG_PAIR_A  = 3'd0,
    REG_PAIR_B  = 3'd1,
    REG_PAIR_C  = 3'd2,
    REG_PAIR_D  = 3'd3,
    REG_CORNER  = 3'd4
  } cfg_idx_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     dividend;
    logic [AccW-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivW-1:0]     quotient;
  } div_rsp_t;

endpackage

FILE: hdl/sampson_error_accumulator_unit.sv
// Top level of the Sampson error accumulator: sequencer, shared MAC and divider.
//
// One point correspondence enters on the in_ channel; one result leaves on out_.
// in_tdata holds first_x, first_y, second_x, second_y (16 bits each, signed) and
// in_tlast marks the final pair of a set. out_tdata holds pair_error (48 bits)
// then running_total (63 bits); out_tuser holds degenerate (bit 0) and
// total_done (bit 1); out_tlast repeats total_done.
// The matrix F is written through cfg_; the user must write it only while the
// block is idle, as the block itself does not enforce this. A single signed
// 32x16 multiply-accumulate unit forms the three epipolar line terms and the
// two gradient terms. Two 32x32 product paths then build the numerator, the
// four squared denominator terms and the square of the numerator, and a
// restoring divider forms the quotient one bit at a time; a zero denominator
// skips the divider and saturates pair_error with degenerate set. in_tready is
// low from acceptance until the result has been taken, so a new item is not
// accepted before the previous result leaves. A stalled receiver holds the
// result and the block. Synchronous reset clears F, the total and all control.
module sampson_error_accumulator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // first_x, first_y, second_x, second_y
  input  logic         in_tlast,   // last_pair
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // pair_error, running_total, zero pad
  output logic [1:0]   out_tuser,  // degenerate, total_done
  output logic         out_tlast   // total_done
);
  localparam int CW = seau_pkg::CoefW;
  localparam int XW = seau_pkg::CoordW;

  typedef enum logic [2:0] {
    S_IDLE, S_LINE, S_SQR, S_DIV, S_WAIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic signed [CW-1:0] f_r [9];
  logic signed [XW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic                 last_r;
  logic [5:0]           step_r, step_nxt;
  logic signed [CW-1:0] red_r [5];       // l0 l1 l2 g0 g1, units 2^-(13+CFB)
  logic [seau_pkg::SumW-1:0] sum_r;
  logic [seau_pkg::ErrW-1:0] err_r;
  logic [seau_pkg::SumW-1:0] tot_r;
  logic                 flag_r, done_r, ov_r;
  logic signed [seau_pkg::AccW-1:0] num_r;
  logic [seau_pkg::AccW-1:0] den_r;

  // Shared multiplier operands.
  logic signed [CW-1:0] mac_a;
  logic signed [XW-1:0] mac_b;
  logic                 mac_clr, mac_en;
  logic signed [seau_pkg::AccW-1:0] mac_acc;

  seau_mac u_mac (
    .clk (clk), .clr (mac_clr), .en (mac_en),
    .a (mac_a), .b (mac_b), .acc (mac_acc)
  );

  seau_pkg::div_req_t div_req;
  seau_pkg::div_rsp_t div_rsp;

  seau_div u_div (.clk (clk), .rst_n (rst_n), .req (div_req), .rsp (div_rsp));

  localparam logic signed [XW-1:0] One = XW'(1 << seau_pkg::CoordFracBits);

  // Line phase: 5 sums of three products, step = 3*k + j, product issued at step.
  // For steps up to 16, k is (11 * step) >> 5.
  logic [2:0] lk;
  logic [1:0] lj;
  logic [3:0] lidx;
  always_comb begin
    lk = 3'(({4'd0, step_r} * 10'd11) >> 5);
    lj = 2'(step_r - 6'(lk) * 6'd3);
    lidx = '0;
    mac_b = One;
    if (lk < 3'd3) begin
      lidx = 4'(lk) * 4'd3 + 4'(lj);
      unique case (lj)
        2'd0:    mac_b = x1_r;
        2'd1:    mac_b = y1_r;
        default: mac_b = One;
      endcase
    end else begin
      lidx = 4'(lj) * 4'd3 + ((lk == 3'd3) ? 4'd0 : 4'd1);
      unique case (lj)
        2'd0:    mac_b = x2_r;
        2'd1:    mac_b = y2_r;
        default: mac_b = One;
      endcase
    end
    mac_a = f_r[lidx];
  end

  // Square phase uses a second 32x32 product path, one per cycle.
  logic signed [CW-1:0]   sq_a, sq_b;
  logic signed [2*CW-1:0] sq_p_r;
  logic [2:0]             sq_sel;
  always_comb begin
    sq_sel = 3'(step_r);
    sq_a = '0;
    sq_b = '0;
    unique case (sq_sel)
      3'd0: begin sq_a = red_r[0]; sq_b = CW'(x2_r); end
      3'd1: begin sq_a = red_r[1]; sq_b = CW'(y2_r); end
      3'd2: begin sq_a = red_r[2]; sq_b = CW'(One);  end
      3'd3: begin sq_a = red_r[3]; sq_b = red_r[3]; end
      3'd4: begin sq_a = red_r[4]; sq_b = red_r[4]; end
      3'd5: begin sq_a = red_r[0]; sq_b = red_r[0]; end
      3'd6: begin sq_a = red_r[1]; sq_b = red_r[1]; end
      default: begin sq_a = '0; sq_b = '0; end
    endcase
  end

  // n fits well under 2^63; its square needs 126 bits, built from 32-bit halves
  // over four registered steps.
  logic [63:0]  nabs;
  logic [31:0]  n_hi, n_lo;
  logic [63:0]  pp_r;
  logic [127:0] nsq_r;
  logic [127:0] dividend;
  assign nabs = num_r[63] ? 64'(-num_r) : 64'(num_r);
  assign n_hi = nabs[63:32];
  assign n_lo = nabs[31:0];

  logic [31:0] pm_a, pm_b;
  always_comb begin
    unique case (step_r[1:0])
      2'd0:    begin pm_a = n_lo; pm_b = n_lo; end
      2'd1:    begin pm_a = n_hi; pm_b = n_lo; end
      2'd2:    begin pm_a = n_lo; pm_b = n_hi; end
      default: begin pm_a = n_hi; pm_b = n_hi; end
    endcase
  end

  always_comb begin
    if (seau_pkg::ErrShift >= 0) begin
      dividend = nsq_r << seau_pkg::ErrShift;
    end else begin
      dividend = nsq_r;
    end
  end

  logic [127:0] quo;
  assign quo = (seau_pkg::ErrShift < 0) ? (div_rsp.quotient >> (-seau_pkg::ErrShift))
                                        : div_rsp.quotient;

  logic signed [seau_pkg::AccW-1:0] red_full;
  assign red_full = mac_acc >>> seau_pkg::LineShift;

  logic [seau_pkg::SumW:0] sum_add;
  logic [seau_pkg::ErrW-1:0] err_v;
  logic                      sat_v;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    mac_clr   = 1'b0;
    mac_en    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = dividend;
    div_req.divisor  = den_r;
    err_v = seau_pkg::ErrMax;
    sat_v = 1'b1;
    if (quo[127:seau_pkg::ErrW] == '0) begin
      err_v = quo[seau_pkg::ErrW-1:0];
      sat_v = 1'b0;
    end
    sum_add = {1'b0, sum_r} + (seau_pkg::SumW+1)'(err_r);
    unique case (state_r)
      S_IDLE: begin
        mac_clr = 1'b1;
        step_nxt = '0;
        if (in_tvalid) begin
          state_nxt = S_LINE;
        end
      end
      S_LINE: begin
        mac_en = 1'b1;
        // The first product of each sum replaces the previous sum.
        mac_clr = (lj == 2'd0);
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd15) begin
          mac_en = 1'b0;
          state_nxt = S_SQR;
          step_nxt = '0;
        end
      end
      S_SQR: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd16) begin
          state_nxt = S_DIV;
          step_nxt = '0;
        end
      end
      S_DIV: begin
        if (den_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_OUT;
        end
      end
      default: begin
        if (out_tvalid && out_tready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      sum_r   <= '0;
      for (int i = 0; i < 9; i++) f_r[i] <= '0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          seau_pkg::REG_PAIR_A: begin f_r[0] <= cfg_wdata[63:32]; f_r[1] <= cfg_wdata[31:0]; end
          seau_pkg::REG_PAIR_B: begin f_r[2] <= cfg_wdata[63:32]; f_r[3] <= cfg_wdata[31:0]; end
          seau_pkg::REG_PAIR_C: begin f_r[4] <= cfg_wdata[63:32]; f_r[5] <= cfg_wdata[31:0]; end
          seau_pkg::REG_PAIR_D: begin f_r[6] <= cfg_wdata[63:32]; f_r[7] <= cfg_wdata[31:0]; end
          seau_pkg::REG_CORNER: f_r[8] <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && !out_tvalid) begin
        out_tvalid <= 1'b1;
        if (sum_add > {1'b0, seau_pkg::SumMax}) begin
          tot_r <= seau_pkg::SumMax;
          flag_r <= ov_r | 1'b1;
          sum_r <= last_r ? '0 : seau_pkg::SumMax;
        end else begin
          tot_r <= sum_add[seau_pkg::SumW-1:0];
          flag_r <= ov_r;
          sum_r <= last_r ? '0 : sum_add[seau_pkg::SumW-1:0];
        end
        done_r <= last_r;
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
    if (state_r == S_IDLE && in_tvalid) begin
      x1_r <= in_tdata[15:0];
      y1_r <= in_tdata[31:16];
      x2_r <= in_tdata[47:32];
      y2_r <= in_tdata[63:48];
      last_r <= in_tlast;
    end
    // Capture each floored sum in the cycle after its third product lands.
    if (state_r == S_LINE && step_r != '0 && lj == 2'd0) begin
      red_r[3'(lk - 3'd1)] <= CW'(red_full);
    end
    // Square phase: products for n (0..2), denominator (3..6), then n squared (8..11).
    if (state_r == S_SQR) begin
      sq_p_r <= sq_a * sq_b;
      pp_r   <= 64'(pm_a) * 64'(pm_b);
      if (step_r == 6'd0) begin
        num_r <= '0;
        den_r <= '0;
      end
      if (step_r >= 6'd1 && step_r <= 6'd3) num_r <= num_r + 64'(sq_p_r);
      if (step_r >= 6'd4 && step_r <= 6'd7) den_r <= den_r + 64'(sq_p_r);
      if (step_r == 6'd8) nsq_r <= '0;
      if (step_r >= 6'd9 && step_r <= 6'd12) begin
        unique case (step_r[1:0])
          2'd1:    nsq_r <= nsq_r + 128'(pp_r);
          2'd2:    nsq_r <= nsq_r + (128'(pp_r) << 32);
          2'd3:    nsq_r <= nsq_r + (128'(pp_r) << 32);
          default: nsq_r <= nsq_r + (128'(pp_r) << 64);
        endcase
      end
    end
    if (state_r == S_DIV && den_r == '0) begin
      err_r <= seau_pkg::ErrMax;
      ov_r  <= 1'b1;
    end
    if (state_r == S_WAIT && div_rsp.done) begin
      err_r <= err_v;
      ov_r  <= sat_v;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tdata = {1'b0, tot_r, err_r};
  assign out_tuser = {done_r, flag_r};
  assign out_tlast = done_r;

endmodule

FILE: hdl/seau_mac.sv
// Shared signed multiply-accumulate unit with a registered accumulator.
module seau_mac (
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        en,
  input  logic signed [seau_pkg::CoefW-1:0]  a,
  input  logic signed [seau_pkg::CoordW-1:0] b,
  output logic signed [seau_pkg::AccW-1:0]   acc
);
  logic signed [seau_pkg::ProdW-1:0] prod;
  logic signed [seau_pkg::AccW-1:0]  acc_r, acc_nxt;

  assign prod = a * b;

  // A clear together with an enable starts a new sum with the current product.
  always_comb begin
    acc_nxt = acc_r;
    if (clr) begin
      acc_nxt = '0;
    end
    if (en) begin
      acc_nxt = acc_nxt + seau_pkg::AccW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;
endmodule

FILE: hdl/seau_div.sv
// Restoring divider, one quotient bit per cycle.
module seau_div (
  input  logic                clk,
  input  logic                rst_n,
  input  seau_pkg::div_req_t  req,
  output seau_pkg::div_rsp_t  rsp
);
  logic [seau_pkg::DivW-1:0] num_r, num_nxt, q_r, q_nxt;
  logic [seau_pkg::AccW:0]   rem_r, rem_nxt, trial;
  logic [seau_pkg::AccW-1:0] d_r, d_nxt;
  logic [7:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[seau_pkg::AccW-1:0], num_r[seau_pkg::DivW-1]};
    if (req.start) begin
      num_nxt  = req.dividend;
      d_nxt    = req.divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = 8'(seau_pkg::DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[seau_pkg::DivW-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[seau_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[seau_pkg::DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;
endmodule

FILE: hdl/seau_checker.sv
// Port-level checks for the Sampson error accumulator, bound to the top level.
module seau_props (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  a_last_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == out_tuser[1])) else $error("tlast and total_done differ");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");

  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tdata, out_tuser, out_tlast}))
    else $error("result carries unknown bits");
endmodule

bind sampson_error_accumulator_unit seau_props u_seau_props (
  .clk (clk), .rst_n (rst_n), .in_tvalid (in_tvalid), .in_tready (in_tready),
  .out_tvalid (out_tvalid), .out_tready (out_tready), .out_tdata (out_tdata),
  .out_tuser (out_tuser), .out_tlast (out_tlast)
);
